// ----- hw/rtl/qrs_pkg.sv -----
// Shared types and codes for the quadratic root solver.
package qrs_pkg;

   localparam int FIELD_W = 32;

   typedef enum logic [1:0] {
      NAT_NONE    = 2'd0,
      NAT_REAL    = 2'd1,
      NAT_REPEAT  = 2'd2,
      NAT_COMPLEX = 2'd3
   } nature_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] coef_a;
      logic signed [FIELD_W-1:0] coef_b;
      logic signed [FIELD_W-1:0] coef_c;
   } req_type;

   typedef struct packed {
      logic [1:0]                nature;
      logic signed [FIELD_W-1:0] first_value;
      logic signed [FIELD_W-1:0] second_value;
   } rsp_type;

   typedef struct packed {
      logic a_zero;
      logic a_neg;
      logic b_neg;
      logic d_neg;
      logic d_zero;
   } flag_type;

endpackage

// ----- hw/rtl/qrs_disc.sv -----
// Three-stage discriminant unit: capture, square and product, combine.
module qrs_disc #(
   parameter int W = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  qrs_pkg::req_type   in_data,
   output logic               out_valid,
   output logic [2*W+1:0]     out_mag,
   output qrs_pkg::flag_type  out_flags,
   output logic [W-1:0]       out_a_mag,
   output logic [W-1:0]       out_b_mag
);
   import qrs_pkg::*;

   logic              v0_ff, v1_ff, v2_ff;
   logic signed [W-1:0] a_ff, b_ff, c_ff;
   logic [W-1:0]      a_mag, b_mag, c_mag;
   logic [2*W-1:0]    bsq_in, pm_in, bsq_ff, pm_ff;
   logic              cross_ff, a_zero1_ff, a_neg1_ff, b_neg1_ff;
   logic [W-1:0]      am1_ff, bm1_ff;
   logic [2*W+1:0]    q4, bsq_x, d_in, d_ff;
   logic              dneg_in;
   logic              dneg_ff, a_zero2_ff, a_neg2_ff, b_neg2_ff;
   logic [W-1:0]      am2_ff, bm2_ff;

   assign a_mag  = a_ff[W-1] ? W'(-a_ff) : W'(a_ff);
   assign b_mag  = b_ff[W-1] ? W'(-b_ff) : W'(b_ff);
   assign c_mag  = c_ff[W-1] ? W'(-c_ff) : W'(c_ff);
   assign bsq_in = b_mag * b_mag;
   assign pm_in  = a_mag * c_mag;

   assign q4    = {pm_ff, 2'b00};
   assign bsq_x = {2'b00, bsq_ff};
   always_comb begin
      dneg_in = 1'b0;
      if (cross_ff) begin
         d_in = bsq_x + q4;
      end else if (bsq_x >= q4) begin
         d_in = bsq_x - q4;
      end else begin
         d_in    = q4 - bsq_x;
         dneg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      a_ff       <= in_data.coef_a[W-1:0];
      b_ff       <= in_data.coef_b[W-1:0];
      c_ff       <= in_data.coef_c[W-1:0];
      bsq_ff     <= bsq_in;
      pm_ff      <= pm_in;
      cross_ff   <= (c_ff != '0) && (a_ff[W-1] != c_ff[W-1]);
      a_zero1_ff <= (a_ff == '0);
      a_neg1_ff  <= a_ff[W-1];
      b_neg1_ff  <= b_ff[W-1];
      am1_ff     <= a_mag;
      bm1_ff     <= b_mag;
      d_ff       <= d_in;
      dneg_ff    <= dneg_in;
      a_zero2_ff <= a_zero1_ff;
      a_neg2_ff  <= a_neg1_ff;
      b_neg2_ff  <= b_neg1_ff;
      am2_ff     <= am1_ff;
      bm2_ff     <= bm1_ff;
   end

   assign out_valid        = v2_ff;
   assign out_mag          = d_ff;
   assign out_flags.a_zero = a_zero2_ff;
   assign out_flags.a_neg  = a_neg2_ff;
   assign out_flags.b_neg  = b_neg2_ff;
   assign out_flags.d_neg  = dneg_ff;
   assign out_flags.d_zero = (d_ff == '0);
   assign out_a_mag        = am2_ff;
   assign out_b_mag        = bm2_ff;

endmodule

// ----- hw/rtl/qrs_sqrt.sv -----
// Pipelined floor square root, one result bit per stage.
module qrs_sqrt #(
   parameter int W    = 32,
   parameter int SB_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [2*W+1:0]    in_rad,
   input  logic [SB_W-1:0]   in_sb,
   output logic              out_valid,
   output logic [W:0]        out_root,
   output logic [SB_W-1:0]   out_sb
);
   localparam int NS = W + 1;
   localparam int DW = 2 * W + 2;
   localparam int RW = W + 3;

   logic            v_ff    [NS];
   logic [DW-1:0]   rad_ff  [NS];
   logic [RW-1:0]   rem_ff  [NS];
   logic [W:0]      root_ff [NS];
   logic [SB_W-1:0] sb_ff   [NS];
   logic            v_cur    [NS];
   logic [DW-1:0]   rad_cur  [NS];
   logic [RW-1:0]   rem_cur  [NS];
   logic [W:0]      root_cur [NS];
   logic [SB_W-1:0] sb_cur   [NS];

   for (genvar i = 0; i < NS; i++) begin : g_stage
      logic [RW-1:0] rem_t, trial;
      logic          ge;
      if (i == 0) begin : g_head
         assign v_cur[i]    = in_valid;
         assign rad_cur[i]  = in_rad;
         assign rem_cur[i]  = '0;
         assign root_cur[i] = '0;
         assign sb_cur[i]   = in_sb;
      end else begin : g_link
         assign v_cur[i]    = v_ff[i-1];
         assign rad_cur[i]  = rad_ff[i-1];
         assign rem_cur[i]  = rem_ff[i-1];
         assign root_cur[i] = root_ff[i-1];
         assign sb_cur[i]   = sb_ff[i-1];
      end
      assign rem_t = {rem_cur[i][RW-3:0], rad_cur[i][DW-1 -: 2]};
      assign trial = {root_cur[i], 2'b01};
      assign ge    = (rem_t >= trial);
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else begin
            v_ff[i] <= v_cur[i];
         end
         rad_ff[i]  <= rad_cur[i] << 2;
         rem_ff[i]  <= ge ? rem_t - trial : rem_t;
         root_ff[i] <= {root_cur[i][W-1:0], ge};
         sb_ff[i]   <= sb_cur[i];
      end
   end

   assign out_valid = v_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_sb    = sb_ff[NS-1];

endmodule

// ----- hw/rtl/qrs_div.sv -----
// Two-lane pipelined restoring divider with signed saturation.
module qrs_div #(
   parameter int W    = 32,
   parameter int F    = 16,
   parameter int SB_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [1:0][W+1:0]    in_mag,
   input  logic [1:0]           in_neg,
   input  logic [W:0]           in_den,
   input  logic [SB_W-1:0]      in_sb,
   output logic                 out_valid,
   output logic [1:0][W-1:0]    out_quo,
   output logic [SB_W-1:0]      out_sb
);
   localparam int XW = W + 2 + F;

   logic                   v_ff   [XW];
   logic [1:0][XW-1:0]     x_ff   [XW];
   logic [1:0][W+1:0]      rem_ff [XW];
   logic [1:0][XW-1:0]     q_ff   [XW];
   logic [1:0]             neg_ff [XW];
   logic [W:0]             den_ff [XW];
   logic [SB_W-1:0]        sb_ff  [XW];
   logic                   v_cur   [XW];
   logic [1:0][XW-1:0]     x_cur   [XW];
   logic [1:0][W+1:0]      rem_cur [XW];
   logic [1:0][XW-1:0]     q_cur   [XW];
   logic [1:0]             neg_cur [XW];
   logic [W:0]             den_cur [XW];
   logic [SB_W-1:0]        sb_cur  [XW];

   for (genvar i = 0; i < XW; i++) begin : g_stage
      logic [1:0][W+1:0]  rem_in;
      logic [1:0][XW-1:0] q_in;
      if (i == 0) begin : g_head
         assign v_cur[i]    = in_valid;
         assign x_cur[i][0] = XW'(in_mag[0]) << F;
         assign x_cur[i][1] = XW'(in_mag[1]) << F;
         assign rem_cur[i]  = '0;
         assign q_cur[i]    = '0;
         assign neg_cur[i]  = in_neg;
         assign den_cur[i]  = in_den;
         assign sb_cur[i]   = in_sb;
      end else begin : g_link
         assign v_cur[i]   = v_ff[i-1];
         assign x_cur[i]   = x_ff[i-1];
         assign rem_cur[i] = rem_ff[i-1];
         assign q_cur[i]   = q_ff[i-1];
         assign neg_cur[i] = neg_ff[i-1];
         assign den_cur[i] = den_ff[i-1];
         assign sb_cur[i]  = sb_ff[i-1];
      end
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [W+1:0] r_t;
         logic         ge;
         assign r_t       = {rem_cur[i][l][W:0], x_cur[i][l][XW-1]};
         assign ge        = (r_t >= {1'b0, den_cur[i]});
         assign rem_in[l] = ge ? r_t - {1'b0, den_cur[i]} : r_t;
         assign q_in[l]   = {q_cur[i][l][XW-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else begin
            v_ff[i] <= v_cur[i];
         end
         x_ff[i][0] <= x_cur[i][0] << 1;
         x_ff[i][1] <= x_cur[i][1] << 1;
         rem_ff[i]  <= rem_in;
         q_ff[i]    <= q_in;
         neg_ff[i]  <= neg_cur[i];
         den_ff[i]  <= den_cur[i];
         sb_ff[i]   <= sb_cur[i];
      end
   end

   localparam logic [XW-1:0] LIM = XW'(1) << (W - 1);

   logic               valid_ff;
   logic [1:0][W-1:0]  quo_in, quo_ff;
   logic [SB_W-1:0]    osb_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         if (neg_ff[XW-1][l]) begin
            quo_in[l] = (q_ff[XW-1][l] > LIM) ? W'(XW'(0) - LIM)
                                              : W'(XW'(0) - q_ff[XW-1][l]);
         end else begin
            quo_in[l] = (q_ff[XW-1][l] > LIM - XW'(1)) ? W'(LIM - XW'(1))
                                                       : W'(q_ff[XW-1][l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= v_ff[XW-1];
      end
      quo_ff <= quo_in;
      osb_ff <= sb_ff[XW-1];
   end

   assign out_valid = valid_ff;
   assign out_quo   = quo_ff;
   assign out_sb    = osb_ff;

endmodule

// ----- hw/rtl/quadratic_root_solver.sv -----
// Quadratic root solver: discriminant, square root and divide pipeline.
// One stage per root bit in the square root and one per quotient bit in the divider.
// Throughput one request per cycle; busy never rises and results cannot be stalled.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
module quadratic_root_solver #(
   parameter int FRAC_BITS  = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  qrs_pkg::req_type  req_data,
   output logic              rsp_valid,
   output qrs_pkg::rsp_type  rsp_data
);
   import qrs_pkg::*;

   localparam int W    = DATA_WIDTH;
   localparam int NW   = W + 3;
   localparam int SQ_W = $bits(flag_type) + 2 * W;

   logic            d_valid;
   logic [2*W+1:0]  d_mag;
   flag_type        d_flags;
   logic [W-1:0]    d_a_mag, d_b_mag;

   logic            sq_valid;
   logic [W:0]      sq_root;
   logic [SQ_W-1:0] sq_sb;
   flag_type        sq_flags;
   logic [W-1:0]    sq_a_mag, sq_b_mag;

   logic signed [NW-1:0] neg_b, sv, n1, n2, abs1, abs2;
   nature_type           nat_in;

   logic              n_valid_ff;
   logic [1:0][W+1:0] n_mag_ff;
   logic [1:0]        n_neg_ff;
   logic [W:0]        n_den_ff;
   logic [1:0]        n_nature_ff;

   logic              q_valid;
   logic [1:0][W-1:0] q_quo;
   logic [1:0]        q_nature;

   assign busy = 1'b0;

   qrs_disc #(.W(W)) u_disc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (d_valid),
      .out_mag   (d_mag),
      .out_flags (d_flags),
      .out_a_mag (d_a_mag),
      .out_b_mag (d_b_mag)
   );

   qrs_sqrt #(.W(W), .SB_W(SQ_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_rad    (d_mag),
      .in_sb     ({d_flags, d_a_mag, d_b_mag}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_sb    (sq_sb)
   );

   assign {sq_flags, sq_a_mag, sq_b_mag} = sq_sb;

   assign neg_b = sq_flags.b_neg ? $signed({3'b000, sq_b_mag})
                                 : -$signed({3'b000, sq_b_mag});
   assign sv    = $signed({2'b00, sq_root});

   always_comb begin
      if (sq_flags.d_neg) begin
         n1 = neg_b;
         n2 = sv;
      end else if (sq_flags.d_zero) begin
         n1 = neg_b;
         n2 = neg_b;
      end else begin
         n1 = neg_b + sv;
         n2 = neg_b - sv;
      end
      if (sq_flags.a_zero) begin
         nat_in = NAT_NONE;
      end else if (sq_flags.d_neg) begin
         nat_in = NAT_COMPLEX;
      end else if (sq_flags.d_zero) begin
         nat_in = NAT_REPEAT;
      end else begin
         nat_in = NAT_REAL;
      end
   end

   assign abs1 = n1[NW-1] ? -n1 : n1;
   assign abs2 = n2[NW-1] ? -n2 : n2;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else begin
         n_valid_ff <= sq_valid;
      end
      n_mag_ff[0] <= abs1[W+1:0];
      n_mag_ff[1] <= abs2[W+1:0];
      n_neg_ff[0] <= n1[NW-1] ^ sq_flags.a_neg;
      n_neg_ff[1] <= n2[NW-1] ^ (sq_flags.a_neg && !sq_flags.d_neg);
      n_den_ff    <= {sq_a_mag, 1'b0};
      n_nature_ff <= nat_in;
   end

   qrs_div #(.W(W), .F(FRAC_BITS), .SB_W(2)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (n_valid_ff),
      .in_mag    (n_mag_ff),
      .in_neg    (n_neg_ff),
      .in_den    (n_den_ff),
      .in_sb     (n_nature_ff),
      .out_valid (q_valid),
      .out_quo   (q_quo),
      .out_sb    (q_nature)
   );

   assign rsp_valid             = q_valid;
   assign rsp_data.nature       = q_nature;
   assign rsp_data.first_value  = (q_nature == NAT_NONE) ? '0 : FIELD_W'(q_quo[0]);
   assign rsp_data.second_value = (q_nature == NAT_NONE) ? '0 : FIELD_W'(q_quo[1]);

`ifndef SYNTHESIS
   a_none_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.nature == NAT_NONE
         |-> rsp_data.first_value == '0 && rsp_data.second_value == '0)
      else $error("not-quadratic response carries nonzero values");

   a_repeat_equal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.nature == NAT_REPEAT
         |-> rsp_data.first_value == rsp_data.second_value)
      else $error("repeated root values differ");

   a_imag_nonneg : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.nature == NAT_COMPLEX |-> !rsp_data.second_value[W-1])
      else $error("imaginary magnitude is negative");
`endif

endmodule
